// ===== rtl/phase_voltage_to_pwm_duty_unit_assert.svh =====
// assertion macros for the phase voltage to pwm duty unit checker
`ifndef PHASE_VOLTAGE_TO_PWM_DUTY_UNIT_ASSERT_SVH
`define PHASE_VOLTAGE_TO_PWM_DUTY_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PVD_ASSERT_NOW(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error("pvd check failed");

// next-cycle implication, disabled during reset
`define PVD_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error("pvd check failed");

`endif

// ===== rtl/pvd_pkg.sv =====
// shared types and constants of the phase voltage to pwm duty unit
package pvd_pkg;

    localparam int LANES     = 3;
    localparam int DIV_STEPS = 15;   // quotient bits below saturation

    // configuration register indexes
    localparam logic [1:0] CFG_BUS_MIN      = 2'd0;
    localparam logic [1:0] CFG_DUTY_FLOOR   = 2'd1;
    localparam logic [1:0] CFG_DUTY_CEILING = 2'd2;

    localparam logic [15:0] RST_BUS_MIN      = 16'd3277;
    localparam logic [14:0] RST_DUTY_FLOOR   = 15'd655;
    localparam logic [14:0] RST_DUTY_CEILING = 15'd32113;

    typedef struct packed {
        logic [15:0] bus_min;
        logic [14:0] duty_floor;
        logic [14:0] duty_ceiling;
    } t_cfg;

    // one phase in flight through the divider
    typedef struct packed {
        logic        neg;
        logic        zero;
        logic        sat;
        logic [16:0] rem;
        logic [14:0] quo;
    } t_lane;

    typedef struct packed {
        logic                    bus_low;
        logic [15:0]             bus;
        t_lane [LANES-1:0]       lane;
    } t_stage;

endpackage

// ===== rtl/pvd_prep.sv =====
// front stage: bus check, magnitude, zero and saturation detect
module pvd_prep (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pvd_pkg::t_cfg                     i_cfg,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [15:0]                       i_bus,
    input  logic [pvd_pkg::LANES-1:0][15:0]   i_volt,
    output logic                              o_valid,
    input  logic                              i_ready,
    output pvd_pkg::t_stage                   o_data
);

    logic            r_valid;
    pvd_pkg::t_stage r_data;
    pvd_pkg::t_stage n_data;
    logic [15:0]     mag [pvd_pkg::LANES];

    always_comb begin
        n_data         = '0;
        n_data.bus     = i_bus;
        n_data.bus_low = (i_bus < i_cfg.bus_min);
        for (int k = 0; k < pvd_pkg::LANES; k++) begin
            mag[k]                = i_volt[k][15] ? (16'd0 - i_volt[k]) : i_volt[k];
            n_data.lane[k].neg    = i_volt[k][15];
            n_data.lane[k].zero   = (mag[k] == 16'd0);
            // quotient of 2^15 or more, also covers a zero bus
            n_data.lane[k].sat    = ({mag[k], 1'b0} >= {1'b0, i_bus});
            n_data.lane[k].rem    = {mag[k], 1'b0};
            n_data.lane[k].quo    = '0;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/pvd_div_step.sv =====
// one restoring division step for all three phases
module pvd_div_step (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  pvd_pkg::t_stage i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output pvd_pkg::t_stage o_data
);

    logic            r_valid;
    pvd_pkg::t_stage r_data;
    pvd_pkg::t_stage n_data;
    logic [16:0]     shifted [pvd_pkg::LANES];
    logic            fits    [pvd_pkg::LANES];

    always_comb begin
        n_data = i_data;
        for (int k = 0; k < pvd_pkg::LANES; k++) begin
            shifted[k]         = {i_data.lane[k].rem[15:0], 1'b0};
            fits[k]            = (shifted[k] >= {1'b0, i_data.bus});
            n_data.lane[k].rem = fits[k] ? (shifted[k] - {1'b0, i_data.bus}) : shifted[k];
            n_data.lane[k].quo = {i_data.lane[k].quo[13:0], fits[k]};
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/pvd_post.sv =====
// output stage: clamp, floor, sign and bus-low forcing into the result register
module pvd_post (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  pvd_pkg::t_cfg                          i_cfg,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  pvd_pkg::t_stage                        i_data,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [pvd_pkg::LANES-1:0][15:0] o_duty,
    output logic                                   o_bus_low
);

    logic                            r_valid;
    logic [pvd_pkg::LANES-1:0][15:0] r_duty;
    logic                            r_bus_low;
    logic [pvd_pkg::LANES-1:0][15:0] n_duty;
    logic [14:0]                     q_clip  [pvd_pkg::LANES];
    logic [14:0]                     q_floor [pvd_pkg::LANES];
    logic [14:0]                     q_fin   [pvd_pkg::LANES];

    always_comb begin
        for (int k = 0; k < pvd_pkg::LANES; k++) begin
            if (i_data.lane[k].zero) begin
                q_clip[k] = '0;
            end else if (i_data.lane[k].sat || (i_data.lane[k].quo > i_cfg.duty_ceiling)) begin
                q_clip[k] = i_cfg.duty_ceiling;
            end else begin
                q_clip[k] = i_data.lane[k].quo;
            end
            q_floor[k] = ((q_clip[k] != '0) && (q_clip[k] < i_cfg.duty_floor))
                         ? i_cfg.duty_floor : q_clip[k];
            // floor above ceiling: ceiling wins
            q_fin[k]   = (q_floor[k] > i_cfg.duty_ceiling) ? i_cfg.duty_ceiling : q_floor[k];
            if (i_data.bus_low) begin
                n_duty[k] = '0;
            end else if (i_data.lane[k].neg) begin
                n_duty[k] = 16'd0 - {1'b0, q_fin[k]};
            end else begin
                n_duty[k] = {1'b0, q_fin[k]};
            end
        end
    end

    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_duty    <= n_duty;
            r_bus_low <= i_data.bus_low;
        end
    end

    assign o_valid   = r_valid;
    assign o_duty    = r_duty;
    assign o_bus_low = r_bus_low;

endmodule

// ===== rtl/phase_voltage_to_pwm_duty_unit.sv =====
// top level of the phase voltage to pwm duty unit
//
//  channel  direction  handshake            payload
//  input    in         i_valid / o_stall    i_bus_voltage, i_volt_a, i_volt_b, i_volt_c
//  result   out        o_valid / i_stall    o_duty_a, o_duty_b, o_duty_c, o_bus_low
//  config   in         i_cfg_we             i_cfg_index, i_cfg_wdata
//
//  one transfer per cycle sustained while i_stall is low; pipeline: front stage, 15 divider
//  stages (one quotient bit each, set by the 17-bit compare and subtract), output register
//  each stage has its own valid bit; an empty stage takes data even when later ones stall
//  o_stall rises only when every stage is full and i_stall is high
//  synchronous active-low reset empties the pipeline and restores the register defaults
module phase_voltage_to_pwm_duty_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic        [15:0] i_bus_voltage,
    input  logic signed [15:0] i_volt_a,
    input  logic signed [15:0] i_volt_b,
    input  logic signed [15:0] i_volt_c,
    // result channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_duty_a,
    output logic signed [15:0] o_duty_b,
    output logic signed [15:0] o_duty_c,
    output logic               o_bus_low,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic        [1:0]  i_cfg_index,
    input  logic        [15:0] i_cfg_wdata
);

    localparam int NSTG = pvd_pkg::DIV_STEPS + 1;   // stage links after the front stage

    pvd_pkg::t_cfg r_cfg;

    // configuration registers; the user must write them only while the pipeline is empty, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bus_min      <= pvd_pkg::RST_BUS_MIN;
            r_cfg.duty_floor   <= pvd_pkg::RST_DUTY_FLOOR;
            r_cfg.duty_ceiling <= pvd_pkg::RST_DUTY_CEILING;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pvd_pkg::CFG_BUS_MIN:      r_cfg.bus_min      <= i_cfg_wdata;
                pvd_pkg::CFG_DUTY_FLOOR:   r_cfg.duty_floor   <= i_cfg_wdata[14:0];
                pvd_pkg::CFG_DUTY_CEILING: r_cfg.duty_ceiling <= i_cfg_wdata[14:0];
                default: ;   // unused index, write dropped
            endcase
        end
    end

    // link k carries the output of stage k (0 = front stage) into stage k+1
    logic                              stg_valid [NSTG];
    logic                              stg_ready [NSTG];
    pvd_pkg::t_stage                   stg_data  [NSTG];
    logic                              in_ready;
    logic [pvd_pkg::LANES-1:0][15:0]   volts;
    logic signed [pvd_pkg::LANES-1:0][15:0] duties;

    assign volts = {i_volt_c, i_volt_b, i_volt_a};

    pvd_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_valid),
        .o_ready (in_ready),
        .i_bus   (i_bus_voltage),
        .i_volt  (volts),
        .o_valid (stg_valid[0]),
        .i_ready (stg_ready[0]),
        .o_data  (stg_data[0])
    );

    // one quotient bit per stage, most significant first
    for (genvar s = 0; s < pvd_pkg::DIV_STEPS; s++) begin : g_div
        pvd_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[s]),
            .o_ready (stg_ready[s]),
            .i_data  (stg_data[s]),
            .o_valid (stg_valid[s+1]),
            .i_ready (stg_ready[s+1]),
            .o_data  (stg_data[s+1])
        );
    end

    pvd_post u_post (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (stg_valid[NSTG-1]),
        .o_ready   (stg_ready[NSTG-1]),
        .i_data    (stg_data[NSTG-1]),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_duty    (duties),
        .o_bus_low (o_bus_low)
    );

    assign o_stall  = !in_ready;
    assign o_duty_a = duties[0];
    assign o_duty_b = duties[1];
    assign o_duty_c = duties[2];

endmodule

// ===== rtl/pvd_checker.sv =====
// port-level checker for the phase voltage to pwm duty unit, with its bind
`include "phase_voltage_to_pwm_duty_unit_assert.svh"

module pvd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_duty_a,
    input logic [15:0] o_duty_b,
    input logic [15:0] o_duty_c,
    input logic        o_bus_low
);

    // a stalled result holds
    `PVD_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_duty_a) && $stable(o_duty_b) && $stable(o_duty_c)
        && $stable(o_bus_low))

    // low bus forces all duties to zero
    `PVD_ASSERT_NOW(a_bus_low_zero, i_clk, i_rst_n, o_valid && o_bus_low,
        (o_duty_a == 16'd0) && (o_duty_b == 16'd0) && (o_duty_c == 16'd0))

    // symmetric clamp never yields the most negative code
    `PVD_ASSERT_NOW(a_no_min_code, i_clk, i_rst_n, o_valid,
        (o_duty_a != 16'h8000) && (o_duty_b != 16'h8000) && (o_duty_c != 16'h8000))

endmodule

bind phase_voltage_to_pwm_duty_unit pvd_checker u_pvd_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_valid   (o_valid),
    .i_stall   (i_stall),
    .o_duty_a  (o_duty_a),
    .o_duty_b  (o_duty_b),
    .o_duty_c  (o_duty_c),
    .o_bus_low (o_bus_low)
);

// ===== bench/phase_voltage_to_pwm_duty_unit_tb.sv =====
// testbench of the phase voltage to pwm duty unit: directed and random transfers checked
// against a built-in duty predictor
`timescale 1ns / 1ps

module phase_voltage_to_pwm_duty_unit_tb;

    // index past the end of the register list, the block must ignore it
    localparam logic [1:0] CFG_NO_REG = 2'd3;
    localparam int MAX_WAIT      = 15;
    localparam int DRAIN_CYCLES  = 40;        // margin beyond the pipeline depth
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct {
        logic signed [15:0] duty_a;
        logic signed [15:0] duty_b;
        logic signed [15:0] duty_c;
        logic               bus_low;
    } t_duty_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic        [15:0] i_bus_voltage = '0;
    logic signed [15:0] i_volt_a = '0;
    logic signed [15:0] i_volt_b = '0;
    logic signed [15:0] i_volt_c = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [15:0] o_duty_a;
    logic signed [15:0] o_duty_b;
    logic signed [15:0] o_duty_c;
    logic               o_bus_low;
    logic               i_cfg_we = 1'b0;
    logic        [1:0]  i_cfg_index = '0;
    logic        [15:0] i_cfg_wdata = '0;

    // predictor copy of the register file
    pvd_pkg::t_cfg  duty_cfg;
    t_duty_result   pending_duties[$];
    int             mismatch_cnt = 0;
    int             cycle_cnt = 0;
    bit             no_idle = 1'b0;   // back-to-back stretch on both sides
    int             rx_hold = 0;

    phase_voltage_to_pwm_duty_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_bus_voltage (i_bus_voltage),
        .i_volt_a      (i_volt_a),
        .i_volt_b      (i_volt_b),
        .i_volt_c      (i_volt_c),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_duty_a      (o_duty_a),
        .o_duty_b      (o_duty_b),
        .o_duty_c      (o_duty_c),
        .o_bus_low     (o_bus_low),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // duty predictor
    // ------------------------------------------------------------------

    // one phase: magnitude divide, truncate toward zero, saturate, floor, clamp
    function automatic logic [15:0] phase_duty_of(logic [15:0] volt, logic [15:0] bus);
        logic        neg;
        logic [16:0] mag;
        logic [47:0] quo;
        neg = volt[15];
        mag = neg ? (17'h10000 - {1'b0, volt}) : {1'b0, volt};
        if (mag == 0) begin
            quo = '0;
        end else if (bus == 0) begin
            // zero divisor saturates by sign
            quo = {33'b0, duty_cfg.duty_ceiling};
        end else begin
            quo = {15'b0, mag, 16'b0} / {32'b0, bus};
            if (quo > duty_cfg.duty_ceiling)
                quo = {33'b0, duty_cfg.duty_ceiling};
        end
        // exact zero stays zero, otherwise raise to the floor
        if (quo != 0 && quo < duty_cfg.duty_floor)
            quo = {33'b0, duty_cfg.duty_floor};
        // the ceiling wins over a floor set above it
        if (quo > duty_cfg.duty_ceiling)
            quo = {33'b0, duty_cfg.duty_ceiling};
        return neg ? (16'h0 - quo[15:0]) : quo[15:0];
    endfunction

    function automatic t_duty_result duties_for(logic [15:0] bus, logic [15:0] va,
                                                logic [15:0] vb, logic [15:0] vc);
        t_duty_result res;
        if (bus < duty_cfg.bus_min) begin
            res.duty_a  = '0;
            res.duty_b  = '0;
            res.duty_c  = '0;
            res.bus_low = 1'b1;
        end else begin
            res.duty_a  = phase_duty_of(va, bus);
            res.duty_b  = phase_duty_of(vb, bus);
            res.duty_c  = phase_duty_of(vc, bus);
            res.bus_low = 1'b0;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // driving side
    // ------------------------------------------------------------------

    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // called right after a rising edge; returns at the edge of the transfer
    // with i_valid still high, so a zero gap keeps valid up without a glitch
    task automatic send_sample(logic [15:0] bus, logic [15:0] va, logic [15:0] vb,
                               logic [15:0] vc);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_bus_voltage <= bus;
        i_volt_a      <= va;
        i_volt_b      <= vb;
        i_volt_c      <= vc;
        do @(posedge i_clk); while (o_stall);
        pending_duties.push_back(duties_for(bus, va, vb, vc));
    endtask

    // drop valid and wait until every expected duty set has come back
    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_duties.size() != 0)
            @(posedge i_clk);
    endtask

    // block must be idle here; predictor copy follows the same masking
    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            pvd_pkg::CFG_BUS_MIN:      duty_cfg.bus_min      = data;
            pvd_pkg::CFG_DUTY_FLOOR:   duty_cfg.duty_floor   = data[14:0];
            pvd_pkg::CFG_DUTY_CEILING: duty_cfg.duty_ceiling = data[14:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // result side: random stall per transfer, check against oldest expectation
    // ------------------------------------------------------------------

    task automatic report_field(string name, logic signed [15:0] want,
                                logic signed [15:0] got);
        if (want !== got) begin
            mismatch_cnt++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    task automatic check_duty_result();
        t_duty_result want;
        if (pending_duties.size() == 0) begin
            mismatch_cnt++;
            $display("%0t: unexpected result transfer, expected none actual %0d %0d %0d %0b",
                     $time, o_duty_a, o_duty_b, o_duty_c, o_bus_low);
            return;
        end
        want = pending_duties.pop_front();
        report_field("duty_a", want.duty_a, o_duty_a);
        report_field("duty_b", want.duty_b, o_duty_b);
        report_field("duty_c", want.duty_c, o_duty_c);
        report_field("bus_low", {15'b0, want.bus_low}, {15'b0, o_bus_low});
    endtask

    always @(posedge i_clk) begin : rx_side
        int hold;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_hold <= 0;
        end else if (o_valid && !i_stall) begin
            check_duty_result();
            hold = draw_wait();
            rx_hold <= hold;
            i_stall <= (hold != 0);
        end else if (rx_hold > 1) begin
            rx_hold <= rx_hold - 1;
        end else begin
            rx_hold <= 0;
            i_stall <= 1'b0;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("** phase_voltage_to_pwm_duty_unit: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // default registers: bus threshold, saturation, floor, zero voltage
    task automatic test_default_config();
        send_sample(16'd3276, 16'sd32767, -16'sd32768, 16'sd1);    // just below bus_min
        send_sample(16'd0, 16'sd100, -16'sd100, 16'sd0);           // dead bus
        send_sample(16'd3277, 16'sd32767, -16'sd32768, 16'sd0);    // at bus_min, saturates
        send_sample(16'hFFFF, 16'sd1, -16'sd1, 16'sd0);            // raised to floor
        send_sample(16'hFFFF, 16'sd16384, -16'sd16384, 16'sd100);
        send_sample(16'd32768, 16'sd16384, -16'sd1, 16'sd2);
        send_sample(16'd40000, 16'sd12345, -16'sd23456, 16'sd7);
        drain_results();
    endtask

    // zero divisor, floor above ceiling, zero ceiling, open limits, ignored index
    task automatic test_special_settings();
        write_reg(pvd_pkg::CFG_BUS_MIN, 16'd0);
        send_sample(16'd0, 16'sd5, -16'sd5, 16'sd0);               // zero divisor by sign
        send_sample(16'd1, 16'sd1, -16'sd1, 16'sd0);
        send_sample(16'd0, 16'sd32767, -16'sd32768, 16'sd0);
        drain_results();
        write_reg(pvd_pkg::CFG_DUTY_FLOOR, 16'h7FFF);
        write_reg(pvd_pkg::CFG_DUTY_CEILING, 16'd100);             // floor above ceiling
        send_sample(16'hFFFF, 16'sd1, -16'sd1, 16'sd0);
        send_sample(16'd16384, 16'sd32767, -16'sd32768, 16'sd3);
        drain_results();
        write_reg(pvd_pkg::CFG_DUTY_CEILING, 16'd0);
        send_sample(16'd40000, 16'sd1000, -16'sd1000, 16'sd0);
        drain_results();
        write_reg(pvd_pkg::CFG_DUTY_FLOOR, 16'h8000);              // top bit dropped
        write_reg(pvd_pkg::CFG_DUTY_CEILING, 16'hFFFF);
        send_sample(16'hFFFF, 16'sd1, -16'sd32768, 16'sd32767);
        send_sample(16'd1, 16'sd1, -16'sd1, 16'sd0);
        drain_results();
        write_reg(CFG_NO_REG, 16'hFFFF);                           // must change nothing
        write_reg(pvd_pkg::CFG_BUS_MIN, 16'hFFFF);
        send_sample(16'hFFFE, 16'sd200, -16'sd200, 16'sd0);
        send_sample(16'hFFFF, 16'sd200, -16'sd200, 16'sd0);
        drain_results();
    endtask

    function automatic logic [15:0] pick_volt();
        logic [15:0] v;
        case ($urandom_range(0, 7))
            5: begin
                v = 16'($urandom_range(0, 64));
                if ($urandom_range(0, 1)) v = 16'h0 - v;
            end
            6: begin
                case ($urandom_range(0, 4))
                    0: v = 16'h8000;
                    1: v = 16'h7FFF;
                    2: v = 16'h0000;
                    3: v = 16'hFFFF;
                    default: v = 16'h0001;
                endcase
            end
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic [15:0] pick_bus();
        logic [15:0] b;
        case ($urandom_range(0, 9))
            6, 7: b = 16'($urandom);
            8:    b = (duty_cfg.bus_min != 0) ? duty_cfg.bus_min - 16'd1 : 16'd0;
            9:    b = duty_cfg.bus_min;
            default: b = 16'($urandom_range(duty_cfg.bus_min, 16'hFFFF));
        endcase
        return b;
    endfunction

    // phases of random traffic, each under its own register setting
    task automatic test_random_traffic(int phases, int per_phase);
        logic [15:0] data;
        for (int p = 0; p < phases; p++) begin
            case ($urandom_range(0, 5))
                0: data = 16'd0;
                1: data = 16'hFFFF;
                2, 3: data = 16'($urandom_range(0, 4000));
                4: data = 16'($urandom);
                default: data = pvd_pkg::RST_BUS_MIN;
            endcase
            write_reg(pvd_pkg::CFG_BUS_MIN, data);
            case ($urandom_range(0, 3))
                0: data = 16'd0;
                1: data = 16'h7FFF;
                2: data = 16'($urandom);
                default: data = 16'($urandom_range(0, 2000));
            endcase
            write_reg(pvd_pkg::CFG_DUTY_FLOOR, data);
            case ($urandom_range(0, 4))
                0: data = 16'h7FFF;
                1: data = 16'd0;
                2: data = 16'($urandom);
                default: data = 16'($urandom_range(20000, 32767));
            endcase
            write_reg(pvd_pkg::CFG_DUTY_CEILING, data);
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_NO_REG, 16'($urandom));
            no_idle = (p % 4 == 3);
            for (int n = 0; n < per_phase; n++)
                send_sample(pick_bus(), pick_volt(), pick_volt(), pick_volt());
            drain_results();
        end
        no_idle = 1'b0;
    endtask

    initial begin
        duty_cfg.bus_min      = pvd_pkg::RST_BUS_MIN;
        duty_cfg.duty_floor   = pvd_pkg::RST_DUTY_FLOOR;
        duty_cfg.duty_ceiling = pvd_pkg::RST_DUTY_CEILING;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_config();
        test_special_settings();
        test_random_traffic(16, 80);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("** phase_voltage_to_pwm_duty_unit: PASSED **");
        else
            $display("** phase_voltage_to_pwm_duty_unit: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/pvd_pkg.sv
rtl/pvd_prep.sv
rtl/pvd_div_step.sv
rtl/pvd_post.sv
rtl/phase_voltage_to_pwm_duty_unit.sv
rtl/pvd_checker.sv
bench/phase_voltage_to_pwm_duty_unit_tb.sv
